>>> design/anud_pkg.sv
// shared types and constants for the annex b nal unit delimiter
`timescale 1ns / 1ps
package anud_pkg;

	localparam int NUM_W       = 32;
	localparam int LEN_FIELD_W = 24;
	localparam int CODE_W      = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int LEVEL_W     = PTR_W + 1;

	localparam logic [7:0]        BYTE_ZERO  = 8'h00;
	localparam logic [7:0]        BYTE_ONE   = 8'h01;
	localparam logic [CODE_W-1:0] CODE_LONG  = 3'd4;
	localparam logic [CODE_W-1:0] CODE_SHORT = 3'd3;

	typedef struct packed {
		logic [NUM_W-1:0]       nal_number;
		logic [LEN_FIELD_W-1:0] nal_length;
		logic [CODE_W-1:0]      start_code_bytes;
		logic                   is_final;
	} result_t;

	// up to two results per byte: a boundary first, then the tail
	typedef struct packed {
		logic    valid0;
		logic    valid1;
		result_t res0;
		result_t res1;
	} push_t;

endpackage

>>> design/anud_scan.sv
// input register, start code detection and unit state
`timescale 1ns / 1ps
module anud_scan import anud_pkg::*; #(
	parameter int LENGTH_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output push_t      push
);

	localparam int LB = LENGTH_BITS;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	logic [23:0]       hist_q;
	logic [LB-1:0]     off_q;
	logic [CODE_W-1:0] size_q;
	logic [NUM_W-1:0]  cnt_q;

	logic              sat;
	logic              zero2;
	logic              zero3;
	logic              is_one;
	logic              long_ok;
	logic              short_ok;
	logic              found;
	logic [LB-1:0]     s_ext;
	logic [LB-1:0]     blen;
	logic [LB-1:0]     off_next;
	logic [CODE_W-1:0] size_next;
	logic [NUM_W-1:0]  cnt_next;
	logic [CODE_W-1:0] new_size;
	result_t           bnd;
	result_t           tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_stream;
		end
	end

	always_comb begin
		sat      = &off_q;
		s_ext    = LB'(size_q);
		zero2    = (hist_q[15:8] == BYTE_ZERO) && (hist_q[7:0] == BYTE_ZERO);
		zero3    = hist_q[23:16] == BYTE_ZERO;
		is_one   = byte_s1 == BYTE_ONE;
		long_ok  = is_one && zero2 && zero3 && (sat || off_q >= s_ext + LB'(3));
		short_ok = is_one && zero2 && !long_ok && (sat || off_q >= s_ext + LB'(2));
		found    = long_ok || short_ok;
		new_size = long_ok ? CODE_LONG : CODE_SHORT;
		blen     = sat ? off_q : off_q - (long_ok ? LB'(3) : LB'(2));

		if (found) begin
			off_next  = LB'(new_size);
			size_next = new_size;
			cnt_next  = cnt_q + NUM_W'(1);
		end else begin
			off_next  = sat ? off_q : off_q + LB'(1);
			size_next = size_q;
			cnt_next  = cnt_q;
		end

		bnd.nal_number       = cnt_q + NUM_W'(1);
		bnd.nal_length       = LEN_FIELD_W'(32'(blen));
		bnd.start_code_bytes = size_q;
		bnd.is_final         = 1'b0;

		tail.nal_number       = cnt_next + NUM_W'(1);
		tail.nal_length       = LEN_FIELD_W'(32'(off_next));
		tail.start_code_bytes = size_next;
		tail.is_final         = 1'b1;

		if (found) begin
			push.valid0 = valid_s1;
			push.res0   = bnd;
			push.valid1 = valid_s1 && last_s1;
			push.res1   = tail;
		end else begin
			push.valid0 = valid_s1 && last_s1;
			push.res0   = tail;
			push.valid1 = 1'b0;
			push.res1   = tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= 24'hFFFFFF;
			off_q  <= '0;
			size_q <= CODE_LONG;
			cnt_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				hist_q <= 24'hFFFFFF;
				off_q  <= '0;
				size_q <= CODE_LONG;
				cnt_q  <= '0;
			end else begin
				hist_q <= {hist_q[15:0], byte_s1};
				off_q  <= off_next;
				size_q <= size_next;
				cnt_q  <= cnt_next;
			end
		end
	end

endmodule

>>> design/anud_fifo.sv
// small result queue with two write slots and one read port
`timescale 1ns / 1ps
module anud_fifo import anud_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	output logic [LEVEL_W-1:0] level,
	output logic               out_valid,
	input  logic               out_ready,
	output result_t            out_res
);

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;
	logic               pop;
	logic [LEVEL_W-1:0] n_push;

	assign out_valid = level_q != '0;
	assign out_res   = mem_q[rd_ptr_q];
	assign level     = level_q;
	assign pop       = out_valid && out_ready;
	assign n_push    = LEVEL_W'(push.valid0) + LEVEL_W'(push.valid1);

	always_ff @(posedge clk) begin
		if (push.valid0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.valid1) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + n_push - LEVEL_W'(pop);
		end
	end

endmodule

>>> design/annexb_nal_unit_delimiter.sv
// top level of the annex b nal unit delimiter
`timescale 1ns / 1ps
// splits an annex b byte stream into nal units at 3- and 4-byte start codes
// s_axis: one stream byte per beat, tlast marks the final byte of the stream
// m_axis: one beat per finished unit (number, length with start code, code size)
//   tlast marks the tail unit reported at stream end, always the last beat
// a byte that completes a start code gives a boundary beat; the final byte
//   gives the tail beat as well, so one byte yields zero, one or two beats
// a beat goes through the byte register and then the result queue to m_axis
// throughput: one byte per cycle while s_axis_tready is high; the byte register
//   feeds the compare and counter logic, which writes a four-entry result queue
// s_axis_tready drops only when the queue could not take the beats of the
//   byte in the register plus two more from the next byte
// when m_axis stalls, the queue fills and then s_axis_tready goes low;
//   nothing is lost or repeated
// reset clears the byte register's valid flag, the unit state and the queue;
//   the block starts as if a 4-byte start code opens the stream
// after the final byte the unit state returns to its reset values
// nal_length saturates at 2^LENGTH_BITS - 1, reported in its low 24 bits
module annexb_nal_unit_delimiter import anud_pkg::*; #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] nal_number, [55:32] nal_length,
	                                    // [58:56] start_code_bytes, [63:59] zero
	output logic        m_axis_tlast    // is_final
);

	logic               accept;
	push_t              push;
	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W:0]   n_push;
	logic [LEVEL_W:0]   fill;
	result_t            out_res;

	// fill once the byte in the register has written its beats
	assign n_push        = (LEVEL_W+1)'(push.valid0) + (LEVEL_W+1)'(push.valid1);
	assign fill          = (LEVEL_W+1)'(level) + n_push;
	assign s_axis_tready = fill <= (LEVEL_W+1)'(FIFO_DEPTH - 2);
	assign accept        = s_axis_tvalid && s_axis_tready;

	anud_scan #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_axis_tdata),
		.end_of_stream (s_axis_tlast),
		.push          (push)
	);

	anud_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack the result beat, first field lowest
	assign m_axis_tdata = {5'b0, out_res.start_code_bytes, out_res.nal_length,
	                       out_res.nal_number};
	assign m_axis_tlast = out_res.is_final;

endmodule

>>> design/anud_checker.sv
// port level checks for the annex b nal unit delimiter
`timescale 1ns / 1ps
module anud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [31:0] exp_num_q;
	logic        out_acc;
	logic        in_acc;

	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign in_acc  = s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata == 8'hFF);

	// units count up by one; numbering restarts after the tail beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_num_q <= 32'd1;
		end else if (out_acc) begin
			exp_num_q <= m_axis_tlast ? 32'd1 : m_axis_tdata[31:0] + 32'd1;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("m_axis beat changed while stalled");

	a_code_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[58:56] == 3'd3) || (m_axis_tdata[58:56] == 3'd4))
		else $error("start code size is neither 3 nor 4");

	a_numbering: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> m_axis_tdata[31:0] == exp_num_q)
		else $error("nal unit number out of sequence");

	a_input_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !(m_axis_tvalid && m_axis_tlast && m_axis_tdata[31:0] == 32'd0
		             && !$past(m_axis_tvalid)))
		else $error("tail beat appeared with a zero unit number");

endmodule

bind annexb_nal_unit_delimiter anud_checker u_anud_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
